@@ design/ftm_pkg.sv @@
// Shared widths and curve constants for the filmic tone map unit.
`default_nettype none
package ftm_pkg;
    localparam int IN_W    = 16;
    localparam int GAIN_W  = 16;
    localparam int X_W     = 24;
    localparam int SQ_W    = 48;
    localparam int REM_W   = 59;
    localparam int Q_W     = 20;
    localparam int P_W     = 36;
    localparam int LAT     = 25;

    localparam logic [REM_W-1:0] K_NUM_SQ  = 59'd210;
    localparam logic [REM_W-1:0] K_NUM_LIN = 59'd102400;
    localparam logic [REM_W-1:0] K_DEN_SQ  = 59'd225;
    localparam logic [REM_W-1:0] K_DEN_LIN = 59'd3072000;
    localparam logic [REM_W-1:0] K_DEN_C   = 59'd1509949440;

    localparam logic ADDR_EXPOSURE = 1'b0;
    localparam logic ADDR_WHITE    = 1'b1;
endpackage
`default_nettype wire

@@ design/ftm_lane.sv @@
// One channel lane: exposure, filmic curve by pipelined division, white scale.
`default_nettype none
module ftm_lane #(
    parameter int CHANNEL_BITS = 16
) (
    input  wire logic                       clk,
    input  wire logic [ftm_pkg::IN_W-1:0]   ch_in,
    input  wire logic [ftm_pkg::GAIN_W-1:0] exposure_gain,
    input  wire logic [ftm_pkg::GAIN_W-1:0] white_scale,
    output logic      [ftm_pkg::IN_W-1:0]   ch_out
);
    import ftm_pkg::*;

    localparam int SHIFT = 32 - CHANNEL_BITS;
    localparam logic [P_W:0] RND  = (37'd1 << SHIFT) >> 1;
    localparam logic [P_W:0] MAXV = (37'd1 << CHANNEL_BITS) - 37'd1;

    logic [X_W-1:0]   x1_reg;
    logic [X_W-1:0]   x2_reg;
    logic [SQ_W-1:0]  sq2_reg;
    logic [REM_W-1:0] rem_reg [0:Q_W];
    logic [REM_W-1:0] den_reg [0:Q_W];
    logic [Q_W-1:0]   q_reg   [0:Q_W];
    logic [P_W-1:0]   p_reg;
    logic [IN_W-1:0]  out_reg;
    logic [31:0]      prod1;
    logic [P_W:0]     v;

    assign prod1 = ch_in * exposure_gain;

    always_ff @(posedge clk)
    begin
        x1_reg     <= prod1[31:8];
        x2_reg     <= x1_reg;
        sq2_reg    <= x1_reg * x1_reg;
        rem_reg[0] <= K_NUM_SQ * {11'd0, sq2_reg} + K_NUM_LIN * {35'd0, x2_reg};
        den_reg[0] <= K_DEN_SQ * {11'd0, sq2_reg} + K_DEN_LIN * {35'd0, x2_reg} + K_DEN_C;
        q_reg[0]   <= '0;
    end

    for (genvar i = 0; i < Q_W; i++)
    begin : g_div
        logic [REM_W-1:0] r2;
        assign r2 = {rem_reg[i][REM_W-2:0], 1'b0};
        always_ff @(posedge clk)
        begin
            den_reg[i+1] <= den_reg[i];
            if (r2 >= den_reg[i])
            begin
                rem_reg[i+1] <= r2 - den_reg[i];
                q_reg[i+1]   <= {q_reg[i][Q_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg[i+1] <= r2;
                q_reg[i+1]   <= {q_reg[i][Q_W-2:0], 1'b0};
            end
        end
    end

    assign v = ({1'b0, p_reg} + RND) >> SHIFT;

    always_ff @(posedge clk)
    begin
        p_reg <= q_reg[Q_W] * white_scale;
        if (v > MAXV)
            out_reg <= MAXV[IN_W-1:0];
        else
            out_reg <= v[IN_W-1:0];
    end

    assign ch_out = out_reg;
endmodule
`default_nettype wire

@@ design/filmic_tone_map_rgb_unit.sv @@
// Top level of the filmic tone map unit: config registers, three lanes, result strobe.
`default_nettype none
// Takes one RGB pixel per clock and returns its tone-mapped value, with done
// high for one cycle. The result passes through the 20-stage division pipeline
// of each channel lane plus five multiply and output stages.
// Busy is never high, so an item may be started in every cycle, and the
// receiver must take each result in the cycle it is shown.
module filmic_tone_map_rgb_unit #(
    parameter int CHANNEL_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [15:0] red_in,
    input  wire logic [15:0] green_in,
    input  wire logic [15:0] blue_in,
    output logic             done,
    output logic      [15:0] red_out,
    output logic      [15:0] green_out,
    output logic      [15:0] blue_out
);
    import ftm_pkg::*;

    logic [GAIN_W-1:0] exposure_reg;
    logic [GAIN_W-1:0] white_reg;
    logic [LAT-1:0]    valid_reg;
    logic [LAT-1:0]    valid_next;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign valid_next = {valid_reg[LAT-2:0], start};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exposure_reg <= 16'd256;
            white_reg    <= 16'd4096;
            valid_reg    <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (psel && penable && pwrite)
            begin
                unique case (paddr[2])
                    ADDR_EXPOSURE: exposure_reg <= pwdata[15:0];
                    ADDR_WHITE:    white_reg    <= pwdata[15:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            ADDR_EXPOSURE: prdata = {16'd0, exposure_reg};
            ADDR_WHITE:    prdata = {16'd0, white_reg};
            default:       prdata = '0;
        endcase
    end

    assign done = valid_reg[LAT-1];

    ftm_lane #(.CHANNEL_BITS(CHANNEL_BITS)) u_red (
        .clk(clk), .ch_in(red_in), .exposure_gain(exposure_reg),
        .white_scale(white_reg), .ch_out(red_out)
    );
    ftm_lane #(.CHANNEL_BITS(CHANNEL_BITS)) u_green (
        .clk(clk), .ch_in(green_in), .exposure_gain(exposure_reg),
        .white_scale(white_reg), .ch_out(green_out)
    );
    ftm_lane #(.CHANNEL_BITS(CHANNEL_BITS)) u_blue (
        .clk(clk), .ch_in(blue_in), .exposure_gain(exposure_reg),
        .white_scale(white_reg), .ch_out(blue_out)
    );
endmodule
`default_nettype wire

@@ sim/tb_filmic_tone_map_rgb_unit.sv @@
// Testbench for the filmic tone map unit: random pixels, register changes, result checks.
`default_nettype none
module tb_filmic_tone_map_rgb_unit;
    import ftm_pkg::*;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } pixel_t;

    class tone_scoreboard;
        pixel_t pending_pixels[$];
        int     errors;
        logic [15:0] exposure;
        logic [15:0] white;

        function new();
            errors   = 0;
            exposure = 16'd256;
            white    = 16'd4096;
        endfunction

        function logic [15:0] map_channel(logic [15:0] value);
            logic [63:0] x;
            logic [63:0] num;
            logic [63:0] den;
            logic [63:0] rem;
            logic [63:0] quo;
            logic [63:0] prod;
            logic [63:0] rounded;
            x   = (64'(value) * 64'(exposure)) >> 8;
            num = x * (64'd210 * x + 64'd102400);
            den = 64'd225 * x * x + 64'd3072000 * x + 64'd1509949440;
            rem = num;
            quo = 0;
            for (int i = 0; i < 20; i++)
            begin
                rem = rem << 1;
                quo = quo << 1;
                if (rem >= den)
                begin
                    rem = rem - den;
                    quo[0] = 1'b1;
                end
            end
            prod    = quo * 64'(white);
            rounded = (prod + 64'd32768) >> 16;
            if (rounded > 64'd65535)
                rounded = 64'd65535;
            return rounded[15:0];
        endfunction

        function void note_pixel(pixel_t px);
            pixel_t mapped;
            mapped.red   = map_channel(px.red);
            mapped.green = map_channel(px.green);
            mapped.blue  = map_channel(px.blue);
            pending_pixels.push_back(mapped);
        endfunction

        function void check_pixel(pixel_t got);
            pixel_t want;
            if (pending_pixels.size() == 0)
            begin
                $error("unexpected result item %h", got);
                errors++;
                return;
            end
            want = pending_pixels.pop_front();
            if (got.red !== want.red)
            begin
                $error("red_out expected %0d actual %0d", want.red, got.red);
                errors++;
            end
            if (got.green !== want.green)
            begin
                $error("green_out expected %0d actual %0d", want.green, got.green);
                errors++;
            end
            if (got.blue !== want.blue)
            begin
                $error("blue_out expected %0d actual %0d", want.blue, got.blue);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        start;
    logic        busy;
    logic [15:0] red_in;
    logic [15:0] green_in;
    logic [15:0] blue_in;
    logic        done;
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;

    tone_scoreboard board;
    int quiet_from;
    int quiet_to;

    filmic_tone_map_rgb_unit uut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy), .red_in(red_in), .green_in(green_in),
        .blue_in(blue_in), .done(done), .red_out(red_out), .green_out(green_out),
        .blue_out(blue_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        board = new();
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_pixel({red_out, green_out, blue_out});
        if (rst_n && start && !busy)
            board.note_pixel({red_in, green_in, blue_in});
    end

    task automatic write_reg(input logic addr_bit, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {addr_bit, 2'b00};
        pwdata  <= {16'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr_bit == ADDR_EXPOSURE)
            board.exposure = value;
        else
            board.white = value;
    endtask

    task automatic send_pixel(input logic [15:0] r, input logic [15:0] g,
                              input logic [15:0] b, input bit may_idle);
        if (may_idle)
        begin
            while ($urandom_range(99) < 24)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        end
        start    <= 1'b1;
        red_in   <= r;
        green_in <= g;
        blue_in  <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic drain();
        int guard;
        start <= 1'b0;
        @(posedge clk);
        guard = 0;
        while (board.pending_pixels.size() != 0 && guard < 10000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (LAT + 5) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(255));
            3: return 16'($urandom_range(8191));
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [15:0] gains[6];
        logic [15:0] whites[6];
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= 3'd0;
        pwdata   <= 32'd0;
        start    <= 1'b0;
        red_in   <= 16'd0;
        green_in <= 16'd0;
        blue_in  <= 16'd0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_pixel(16'd0, 16'hFFFF, 16'd4096, 1'b0);
        send_pixel(16'hFFFF, 16'd0, 16'd1, 1'b0);
        send_pixel(16'd2048, 16'd8192, 16'hAAAA, 1'b0);
        send_pixel(16'h5555, 16'd100, 16'd40000, 1'b0);
        drain();
        write_reg(ADDR_EXPOSURE, 16'd0);
        write_reg(ADDR_WHITE, 16'hFFFF);
        send_pixel(16'hFFFF, 16'h1234, 16'd0, 1'b0);
        drain();
        write_reg(ADDR_EXPOSURE, 16'hFFFF);
        send_pixel(16'hFFFF, 16'd1, 16'd4096, 1'b0);
        send_pixel(16'd0, 16'd300, 16'h8000, 1'b0);
        drain();
        write_reg(ADDR_WHITE, 16'd0);
        send_pixel(16'hFFFF, 16'd77, 16'd4096, 1'b0);
        drain();

        gains  = '{16'd256, 16'd1, 16'hFFFF, 16'd1024, 16'd64, 16'd0};
        whites = '{16'd4096, 16'hFFFF, 16'd5000, 16'd0, 16'd8192, 16'd4096};
        for (int phase = 0; phase < 6; phase++)
        begin
            write_reg(ADDR_EXPOSURE, phase < 5 ? gains[phase] : 16'($urandom));
            write_reg(ADDR_WHITE, phase < 5 ? whites[phase] : 16'($urandom));
            quiet_from = $urandom_range(50, 150);
            quiet_to   = quiet_from + 100;
            for (int n = 0; n < 340; n++)
            begin
                if (n == 170)
                    drain();
                send_pixel(pick_value(), pick_value(), pick_value(),
                           !(n >= quiet_from && n < quiet_to));
            end
            drain();
        end

        if (board.errors == 0 && board.pending_pixels.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire
